// File: hdl/acal_pkg.sv
`default_nettype none

package acal_pkg;

  localparam int RAW_W    = 16;
  localparam int SCALED_W = 12;
  localparam int ACC_W    = 24;
  localparam int ONE_G_W  = 11;
  localparam int CNT_W    = 8;
  localparam int AXES     = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIB_ON = 3'd0,
    CFG_OFF_X    = 3'd1,
    CFG_OFF_Y    = 3'd2,
    CFG_OFF_Z    = 3'd3,
    CFG_ONE_G    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              req_type;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  raw_z;
  } in_req_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic                    is_calibrated;
    logic signed [RAW_W-1:0] offset_x_out;
    logic signed [RAW_W-1:0] offset_y_out;
    logic signed [RAW_W-1:0] offset_z_out;
  } out_rsp_t;

  typedef struct packed {
    logic                 calib_on;
    logic [RAW_W-1:0]     stored_x;
    logic [RAW_W-1:0]     stored_y;
    logic [RAW_W-1:0]     stored_z;
    logic [ONE_G_W-1:0]   one_g;
  } cfg_t;

  // Signed divide by 16, truncating toward zero.
  function automatic logic [SCALED_W-1:0] scale16(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] biased;
    biased = raw + (raw[RAW_W-1] ? RAW_W'(15) : RAW_W'(0));
    return biased[RAW_W-1:4];
  endfunction

endpackage

`default_nettype wire

// File: hdl/acal_cfg_regs.sv
`default_nettype none

module acal_cfg_regs
  import acal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CALIB_ON: cfg_nxt.calib_on = cfg_wdata[0];
        CFG_OFF_X:    cfg_nxt.stored_x = cfg_wdata;
        CFG_OFF_Y:    cfg_nxt.stored_y = cfg_wdata;
        CFG_OFF_Z:    cfg_nxt.stored_z = cfg_wdata;
        CFG_ONE_G:    cfg_nxt.one_g    = cfg_wdata[ONE_G_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calib_on <= 1'b1;
      cfg_r.stored_x <= '0;
      cfg_r.stored_y <= '0;
      cfg_r.stored_z <= '0;
      cfg_r.one_g    <= ONE_G_W'(256);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/acal_in_stage.sv
`default_nettype none

module acal_in_stage
  import acal_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_req_t   in_data,
  input  wire logic room,
  output logic      s1_valid,
  output in_req_t   s1_data
);

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  in_req_t s1_data_r;
  logic    accept;

  // Hold the request while the result register cannot take it.
  assign in_stall = s1_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (room) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

`default_nettype wire

// File: hdl/acal_datapath.sv
`default_nettype none

module acal_datapath
  import acal_pkg::*;
#(
  parameter int CALIBRATION_SAMPLES = 100
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  in_req_t   req,
  input  cfg_t      cfg,
  output out_rsp_t  rsp
);

  localparam int SUM_MAX  = (CALIBRATION_SAMPLES - 1) * 2048;
  localparam int ABS_W    = $clog2(SUM_MAX + 1);
  localparam int SHIFT    = ABS_W + $clog2(CALIBRATION_SAMPLES);
  localparam int RECIP_W  = SHIFT;
  localparam int PROD_W   = ABS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + CALIBRATION_SAMPLES - 1) / CALIBRATION_SAMPLES);
  localparam logic [CNT_W-1:0] NSAMP = CNT_W'(CALIBRATION_SAMPLES);

  logic [CNT_W-1:0]             sl_r;
  logic [CNT_W-1:0]             sl_nxt;
  logic [AXES-1:0][ACC_W-1:0]   sum_r;
  logic [AXES-1:0][ACC_W-1:0]   sum_nxt;
  logic [AXES-1:0][RAW_W-1:0]   raw;
  logic [AXES-1:0][RAW_W-1:0]   stored;
  logic [AXES-1:0][SCALED_W-1:0] scaled;
  logic [AXES-1:0][RAW_W-1:0]   accel;
  logic [AXES-1:0][RAW_W-1:0]   offs;
  logic [AXES-1:0][ACC_W-1:0]   quot;
  logic [AXES-1:0][ABS_W-1:0]   mag;
  logic [AXES-1:0][PROD_W-1:0]  prod;
  logic                         restart;
  logic                         cal_done;

  assign raw     = {req.raw_z, req.raw_y, req.raw_x};
  assign stored  = {cfg.stored_z, cfg.stored_y, cfg.stored_x};
  assign restart = (req.req_type == REQ_RESTART);

  // Sum / N by reciprocal multiply; exact over the whole sum range.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [ACC_W-1:0] neg_sum;
      neg_sum = -sum_r[i];
      mag[i]  = sum_r[i][ACC_W-1] ? neg_sum[ABS_W-1:0] : sum_r[i][ABS_W-1:0];
      prod[i] = PROD_W'(mag[i]) * PROD_W'(RECIP);
      quot[i] = ACC_W'(prod[i][PROD_W-1:SHIFT]);
      if (sum_r[i][ACC_W-1]) begin
        quot[i] = -quot[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      scaled[i] = scale16(raw[i]);
    end
    sl_nxt  = sl_r;
    sum_nxt = sum_r;
    accel   = '0;
    if (restart) begin
      if (cfg.calib_on) begin
        sl_nxt  = NSAMP;
        sum_nxt = '0;
      end else begin
        sl_nxt = '0;
        for (int i = 0; i < AXES; i++) begin
          sum_nxt[i] = {{(ACC_W-RAW_W){stored[i][RAW_W-1]}}, stored[i]};
        end
      end
    end else begin
      for (int i = 0; i < AXES; i++) begin
        accel[i] = {{(RAW_W-SCALED_W){scaled[i][SCALED_W-1]}}, scaled[i]};
      end
      if (sl_r != '0) begin
        if (sl_r == CNT_W'(1)) begin
          // Last sample: average, drop gravity from z, do not accumulate.
          sum_nxt    = quot;
          sum_nxt[2] = quot[2] - ACC_W'(cfg.one_g);
        end else begin
          for (int i = 0; i < AXES; i++) begin
            sum_nxt[i] = sum_r[i] +
              {{(ACC_W-SCALED_W){scaled[i][SCALED_W-1]}}, scaled[i]};
          end
        end
        sl_nxt = sl_r - CNT_W'(1);
      end else begin
        for (int i = 0; i < AXES; i++) begin
          accel[i] = accel[i] - sum_r[i][RAW_W-1:0];
        end
      end
    end
    cal_done = (sl_nxt == '0);
    for (int i = 0; i < AXES; i++) begin
      offs[i] = cal_done ? sum_nxt[i][RAW_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r  <= '0;
      sum_r <= '0;
    end else if (fire) begin
      sl_r  <= sl_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign rsp.accel_x       = accel[0];
  assign rsp.accel_y       = accel[1];
  assign rsp.accel_z       = accel[2];
  assign rsp.is_calibrated = cal_done;
  assign rsp.offset_x_out  = offs[0];
  assign rsp.offset_y_out  = offs[1];
  assign rsp.offset_z_out  = offs[2];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    sl_r <= NSAMP)
    else $error("sample counter above calibration length");

  a_restart_arm: assert property (@(posedge clk) disable iff (!rst_n)
    fire && restart && cfg.calib_on |=> sl_r == NSAMP && sum_r == '0)
    else $error("calibrating restart did not arm counter and clear sums");

  a_offset_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !restart && sl_r == '0 |=> $stable(sum_r) && sl_r == '0)
    else $error("offsets changed on a corrected sample");

  a_last_sample: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !restart && sl_r == CNT_W'(1) |=> sl_r == '0)
    else $error("last calibration sample did not finish calibration");

endmodule

`default_nettype wire

// File: hdl/acal_out_stage.sv
`default_nettype none

module acal_out_stage
  import acal_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  out_rsp_t  rsp,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_rsp_t  out_data
);

  logic     out_valid_r;
  logic     out_valid_nxt;
  out_rsp_t out_data_r;

  assign room = !out_valid_r || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/accel_offset_calibrator_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_stall    in_data   (in_req_t)
// out_      result     out_valid / out_stall  out_data  (out_rsp_t)
// cfg_      write      cfg_we                 cfg_index, cfg_wdata
//
// Throughput is one request per cycle while out_stall is low; a request
// passes the input register, then the result register, before out_valid
// rises for its result.
// The calibration state updates in the single pass between the two
// registers, so a request sees the state left by the one before it.
// Reset (rst_n low, synchronous) empties both registers, sets the
// counter and sums to zero and loads the register defaults.
// A stalled result holds; in_stall rises only when both registers are full.

module accel_offset_calibrator_core
  import acal_pkg::*;
#(
  parameter int CALIBRATION_SAMPLES = 100
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  in_req_t                    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_rsp_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  in_req_t  s1_data;
  out_rsp_t rsp;
  logic     s1_valid;
  logic     room;
  logic     fire;

  // Advance the held request into the result register when there is room.
  assign fire = s1_valid && room;

  acal_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  acal_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  acal_datapath #(
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_data),
    .cfg   (cfg),
    .rsp   (rsp)
  );

  acal_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .rsp       (rsp),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
